### hw/rtl/assert_macros.svh
// Assertion macros shared by the filter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/gbf_pkg.sv
// Types, constants and helpers of the gated 3x3 box filter
`timescale 1ns / 1ps

package gbf_pkg;

   localparam int unsigned MAX_LINE   = 1024;
   localparam int unsigned MAX_ROWS   = 1024;
   localparam int unsigned COL_W      = $clog2(MAX_LINE);
   localparam int unsigned ROW_W      = $clog2(MAX_ROWS);
   localparam int unsigned PIX_W      = 8;
   localparam int unsigned LINE_W     = 2 * PIX_W;
   localparam int unsigned SIZE_W     = 11;
   localparam int unsigned COLSUM_W   = PIX_W + 2;
   localparam int unsigned SUM_W      = PIX_W + 4;
   localparam int unsigned PROD_W     = 2 * SUM_W;
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [SIZE_W-1:0] MIN_SIZE           = SIZE_W'(3);
   localparam logic [SIZE_W-1:0] MAX_LINE_SIZE      = SIZE_W'(MAX_LINE);
   localparam logic [SIZE_W-1:0] MAX_ROW_SIZE       = SIZE_W'(MAX_ROWS);
   localparam logic [SIZE_W-1:0] LINE_WIDTH_RESET   = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = SIZE_W'(480);

   localparam logic [PIX_W-1:0] GATE_LEVEL = PIX_W'(128);

   // floor(s / 9) == (s * 3641) >> 15 for every s below 32768
   localparam logic [SUM_W-1:0] DIV9_MUL   = SUM_W'(3641);
   localparam int unsigned      DIV9_SHIFT = 15;

   typedef enum logic [0:0] {
      CSR_LINE_WIDTH   = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // pixel in flight between the address stage and the window stage
   typedef struct packed {
      logic             valid;
      logic             interior;
      logic             last;
      logic             fwd;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] pixel;
   } item_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] r;
      if (v < MIN_SIZE) begin
         r = MIN_SIZE;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### hw/rtl/gbf_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module gbf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/gbf_window.sv
// Window stage: line store write-back, 3x3 sum, divide by nine and gating
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gbf_window (
   input  logic                            clock,
   input  logic                            reset,
   input  gbf_pkg::item_type               stage_b,
   input  logic [gbf_pkg::LINE_W-1:0]      ram_rd_data,
   output logic                            ram_wr_en,
   output logic [gbf_pkg::COL_W-1:0]       ram_wr_addr,
   output logic [gbf_pkg::LINE_W-1:0]      ram_wr_data,
   output logic                            res_valid,
   output logic [gbf_pkg::PIX_W-1:0]       res_value,
   output logic                            res_last
);

   logic [gbf_pkg::LINE_W-1:0]   line_data;
   logic [gbf_pkg::PIX_W-1:0]    up;
   logic [gbf_pkg::PIX_W-1:0]    mid;
   logic [gbf_pkg::COLSUM_W-1:0] cs_new;
   logic [gbf_pkg::SUM_W-1:0]    sum;

   // forwarded line data of the previous pixel, for a read that hit its column
   logic [gbf_pkg::LINE_W-1:0]   fwd_data_ff;
   // column sums of the two older window columns, and the window centre
   logic [gbf_pkg::COLSUM_W-1:0] cs_old_ff;
   logic [gbf_pkg::COLSUM_W-1:0] cs_mid_ff;
   logic [gbf_pkg::PIX_W-1:0]    centre_ff;

   logic                         c_valid_ff;
   logic                         c_last_ff;
   logic [gbf_pkg::SUM_W-1:0]    c_sum_ff;
   logic [gbf_pkg::PIX_W-1:0]    c_centre_ff;

   logic [gbf_pkg::PROD_W-1:0]   product;
   logic [gbf_pkg::PIX_W-1:0]    quotient;

   always_comb begin
      line_data = stage_b.fwd ? fwd_data_ff : ram_rd_data;
      up        = line_data[gbf_pkg::LINE_W-1 -: gbf_pkg::PIX_W];
      mid       = line_data[gbf_pkg::PIX_W-1:0];
      cs_new    = gbf_pkg::COLSUM_W'(up) + gbf_pkg::COLSUM_W'(mid)
                + gbf_pkg::COLSUM_W'(stage_b.pixel);
      sum       = gbf_pkg::SUM_W'(cs_old_ff) + gbf_pkg::SUM_W'(cs_mid_ff)
                + gbf_pkg::SUM_W'(cs_new);
   end

   assign ram_wr_en   = stage_b.valid;
   assign ram_wr_addr = stage_b.col;
   assign ram_wr_data = {mid, stage_b.pixel};

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_old_ff  <= '0;
         cs_mid_ff  <= '0;
         centre_ff  <= '0;
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= stage_b.valid && stage_b.interior;
         if (stage_b.valid) begin
            cs_old_ff <= cs_mid_ff;
            cs_mid_ff <= cs_new;
            centre_ff <= mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_b.valid) begin
         fwd_data_ff <= {mid, stage_b.pixel};
      end
      c_sum_ff    <= sum;
      c_centre_ff <= centre_ff;
      c_last_ff   <= stage_b.last;
   end

   always_comb begin
      product  = gbf_pkg::PROD_W'(c_sum_ff) * gbf_pkg::PROD_W'(gbf_pkg::DIV9_MUL);
      quotient = product[gbf_pkg::DIV9_SHIFT +: gbf_pkg::PIX_W];
   end

   assign res_valid = c_valid_ff;
   assign res_value = (c_centre_ff >= gbf_pkg::GATE_LEVEL) ? quotient : c_centre_ff;
   assign res_last  = c_last_ff;

   `ASSERT_NEXT(win_result_follows_item, stage_b.valid && stage_b.interior, res_valid, "interior pixel gave no result")
   `ASSERT_IMPLY(win_fwd_same_col, stage_b.valid && stage_b.fwd, $past(ram_wr_en) && ($past(ram_wr_addr) == stage_b.col), "forward without matching write")

endmodule

### hw/rtl/gbf_fifo.sv
// Four-entry result queue between the filter pipeline and the result channel
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gbf_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [gbf_pkg::PIX_W-1:0]      push_value,
   input  logic                           push_last,
   input  logic                           pop,
   output logic                           valid,
   output logic [gbf_pkg::PIX_W-1:0]      value,
   output logic                           last,
   output logic [gbf_pkg::FIFO_CNT_W-1:0] count
);

   logic [gbf_pkg::PIX_W-1:0]      value_ff [gbf_pkg::FIFO_DEPTH];
   logic                           last_ff  [gbf_pkg::FIFO_DEPTH];
   logic [gbf_pkg::FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [gbf_pkg::FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [gbf_pkg::FIFO_CNT_W-1:0] count_ff;
   logic [gbf_pkg::FIFO_CNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + gbf_pkg::FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - gbf_pkg::FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + gbf_pkg::FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + gbf_pkg::FIFO_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         value_ff[wr_ptr_ff] <= push_value;
         last_ff[wr_ptr_ff]  <= push_last;
      end
   end

   assign valid = (count_ff != '0);
   assign value = value_ff[rd_ptr_ff];
   assign last  = last_ff[rd_ptr_ff];
   assign count = count_ff;

   `ASSERT_IMPLY(fifo_no_overflow, push && !pop, count_ff < gbf_pkg::FIFO_CNT_W'(gbf_pkg::FIFO_DEPTH), "result queue overflow")
   `ASSERT_ALWAYS(fifo_ptr_count, gbf_pkg::FIFO_PTR_W'(wr_ptr_ff - rd_ptr_ff) == gbf_pkg::FIFO_PTR_W'(count_ff), "queue pointers disagree with count")

endmodule

### hw/rtl/gated_box_filter_3x3_top.sv
// Gated 3x3 box filter over a raster stream of 8-bit grey pixels. One pixel is
// taken per clock while the result queue has room; every interior pixel of the
// frame gives one result, the box mean when the window centre is 128 or more,
// else the centre itself, and border pixels give none. From the pixel that
// completes its window, a result passes the line store read and the window
// sum, then the divide by nine on the registered sum, then the output queue.
// The two line stores share one 16-bit RAM read and written once
// per pixel, and a four-entry output queue takes up result back-pressure.
// The user must write line_width and frame_height through the csr port only
// while no pixel is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gated_box_filter_3x3_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [gbf_pkg::PIX_W-1:0]    req_pixel,
   input  logic                         req_frame_start,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [gbf_pkg::PIX_W-1:0]    rsp_filtered_value,
   output logic                         rsp_frame_last,
   input  logic                         csr_wr_en,
   input  gbf_pkg::csr_index_type       csr_index,
   input  logic [gbf_pkg::SIZE_W-1:0]   csr_wr_data
);

   logic [gbf_pkg::SIZE_W-1:0] line_width_ff;
   logic [gbf_pkg::SIZE_W-1:0] frame_height_ff;
   logic [gbf_pkg::COL_W-1:0]  col_ff;
   logic [gbf_pkg::ROW_W-1:0]  row_ff;
   logic [gbf_pkg::COL_W-1:0]  col_in;
   logic [gbf_pkg::ROW_W-1:0]  row_in;
   gbf_pkg::item_type          stage_b_ff;
   gbf_pkg::item_type          stage_b_in;

   logic [gbf_pkg::SIZE_W-1:0] w_eff;
   logic [gbf_pkg::SIZE_W-1:0] h_eff;
   logic [gbf_pkg::SIZE_W-1:0] c0;
   logic [gbf_pkg::SIZE_W-1:0] r0;
   logic [gbf_pkg::SIZE_W-1:0] c1;
   logic [gbf_pkg::SIZE_W-1:0] r1;
   logic [gbf_pkg::SIZE_W-1:0] r2;
   logic [gbf_pkg::SIZE_W-1:0] cn;
   logic [gbf_pkg::SIZE_W-1:0] rn;
   logic [gbf_pkg::COL_W-1:0]  col_a;
   logic                       req_accept;

   logic [gbf_pkg::LINE_W-1:0] ram_rd_data;
   logic                       ram_wr_en;
   logic [gbf_pkg::COL_W-1:0]  ram_wr_addr;
   logic [gbf_pkg::LINE_W-1:0] ram_wr_data;

   logic                           res_valid;
   logic [gbf_pkg::PIX_W-1:0]      res_value;
   logic                           res_last;
   logic [gbf_pkg::FIFO_CNT_W-1:0] fifo_count;
   logic [gbf_pkg::FIFO_CNT_W:0]   occupancy;
   logic                           rsp_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= gbf_pkg::LINE_WIDTH_RESET;
         frame_height_ff <= gbf_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            gbf_pkg::CSR_LINE_WIDTH:   line_width_ff   <= csr_wr_data;
            gbf_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // position of the incoming pixel, with wrap after a size change
   always_comb begin
      w_eff = gbf_pkg::clamp_size(line_width_ff, gbf_pkg::MAX_LINE_SIZE);
      h_eff = gbf_pkg::clamp_size(frame_height_ff, gbf_pkg::MAX_ROW_SIZE);
      c0    = req_frame_start ? '0 : gbf_pkg::SIZE_W'(col_ff);
      r0    = req_frame_start ? '0 : gbf_pkg::SIZE_W'(row_ff);
      if (c0 >= w_eff) begin
         c1 = '0;
         r1 = r0 + gbf_pkg::SIZE_W'(1);
      end else begin
         c1 = c0;
         r1 = r0;
      end
      r2    = (r1 >= h_eff) ? '0 : r1;
      col_a = c1[gbf_pkg::COL_W-1:0];

      cn = c1 + gbf_pkg::SIZE_W'(1);
      rn = r2;
      if (cn >= w_eff) begin
         cn = '0;
         rn = r2 + gbf_pkg::SIZE_W'(1);
         if (rn >= h_eff) begin
            rn = '0;
         end
      end
      col_in = cn[gbf_pkg::COL_W-1:0];
      row_in = rn[gbf_pkg::ROW_W-1:0];

      stage_b_in.valid    = req_accept;
      stage_b_in.interior = (r2 >= gbf_pkg::SIZE_W'(2)) && (c1 >= gbf_pkg::SIZE_W'(2));
      stage_b_in.last     = (r2 == h_eff - gbf_pkg::SIZE_W'(1))
                         && (c1 == w_eff - gbf_pkg::SIZE_W'(1));
      stage_b_in.fwd      = stage_b_ff.valid && (stage_b_ff.col == col_a);
      stage_b_in.col      = col_a;
      stage_b_in.pixel    = req_pixel;
   end

   assign occupancy  = (gbf_pkg::FIFO_CNT_W+1)'(fifo_count)
                     + (gbf_pkg::FIFO_CNT_W+1)'(res_valid)
                     + (gbf_pkg::FIFO_CNT_W+1)'(stage_b_ff.valid && stage_b_ff.interior);
   assign req_stall  = reset
                    || (occupancy >= (gbf_pkg::FIFO_CNT_W+1)'(gbf_pkg::FIFO_DEPTH));
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         stage_b_ff <= '0;
      end else begin
         stage_b_ff <= stage_b_in;
         if (req_accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   gbf_ram #(
      .WIDTH (gbf_pkg::LINE_W),
      .DEPTH (gbf_pkg::MAX_LINE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (col_a),
      .rd_data (ram_rd_data)
   );

   gbf_window u_window (
      .clock       (clock),
      .reset       (reset),
      .stage_b     (stage_b_ff),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .res_valid   (res_valid),
      .res_value   (res_value),
      .res_last    (res_last)
   );

   assign rsp_pop = rsp_valid && !rsp_stall;

   gbf_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_value (res_value),
      .push_last  (res_last),
      .pop        (rsp_pop),
      .valid      (rsp_valid),
      .value      (rsp_filtered_value),
      .last       (rsp_frame_last),
      .count      (fifo_count)
   );

   `ASSERT_ALWAYS(top_occupancy_bound, occupancy <= (gbf_pkg::FIFO_CNT_W+1)'(gbf_pkg::FIFO_DEPTH), "results in flight exceed queue room")

endmodule

### test/box_filter_checker.sv
// Checker for the gated 3x3 box filter: mirrors the pixel stream, predicts and compares results
`timescale 1ns / 1ps

module box_filter_checker
   import gbf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [PIX_W-1:0]    req_pixel,
   input  logic                req_frame_start,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [PIX_W-1:0]    rsp_filtered_value,
   input  logic                rsp_frame_last,
   input  logic                csr_wr_en,
   input  csr_index_type       csr_index,
   input  logic [SIZE_W-1:0]   csr_wr_data,
   output int                  failures,
   output int                  pending
);

   localparam int unsigned BOX_AREA = 9;

   typedef struct packed {
      logic [PIX_W-1:0] value;
      logic             last;
   } filter_result_type;

   filter_result_type  expected_results[$];
   logic [SIZE_W-1:0]  width_reg;
   logic [SIZE_W-1:0]  height_reg;
   logic [PIX_W-1:0]   upper_row [MAX_LINE];
   logic [PIX_W-1:0]   middle_row [MAX_LINE];
   logic [PIX_W-1:0]   window [6];   // [0..2] oldest column, [3..5] middle column
   int unsigned        col_pos;
   int unsigned        row_pos;

   function automatic int unsigned bounded_size(input int unsigned raw,
                                                input int unsigned top_size);
      if (raw < MIN_SIZE) begin
         return MIN_SIZE;
      end
      if (raw > top_size) begin
         return top_size;
      end
      return raw;
   endfunction

   task automatic filter_pixel(input logic [PIX_W-1:0] pix, input logic fs);
      int unsigned       w;
      int unsigned       h;
      int unsigned       col;
      int unsigned       row;
      int unsigned       sum;
      logic [PIX_W-1:0]  up;
      logic [PIX_W-1:0]  mid;
      filter_result_type res;
      w = bounded_size(width_reg, MAX_LINE);
      h = bounded_size(height_reg, MAX_ROWS);
      col = fs ? 0 : col_pos;
      row = fs ? 0 : row_pos;
      // sizes may have shrunk since the last transfer
      if (col >= w) begin
         col = 0;
         row = row + 1;
      end
      if (row >= h) begin
         row = 0;
      end
      up = upper_row[col];
      mid = middle_row[col];
      if (row >= 2 && col >= 2) begin
         if (window[4] >= GATE_LEVEL) begin
            sum = up + mid + pix;
            for (int k = 0; k < 6; k++) begin
               sum = sum + window[k];
            end
            res.value = PIX_W'(sum / BOX_AREA);
         end else begin
            res.value = window[4];
         end
         res.last = (row == h - 1) && (col == w - 1);
         expected_results.push_back(res);
      end
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = up;
      window[4] = mid;
      window[5] = pix;
      upper_row[col] = mid;
      middle_row[col] = pix;
      col = col + 1;
      if (col >= w) begin
         col = 0;
         row = row + 1;
         if (row >= h) begin
            row = 0;
         end
      end
      col_pos = col;
      row_pos = row;
   endtask

   always @(posedge clock) begin : monitor
      filter_result_type oldest;
      int                new_errors;
      new_errors = 0;
      if (reset) begin
         width_reg = LINE_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         foreach (upper_row[i]) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
         end
         foreach (window[i]) begin
            window[i] = '0;
         end
         col_pos = 0;
         row_pos = 0;
         expected_results.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LINE_WIDTH: width_reg = csr_wr_data;
               CSR_FRAME_HEIGHT: height_reg = csr_wr_data;
               default: ;
            endcase
         end
         // results first, so a transfer never matches a pixel taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: filtered_value %0d, frame_last %0b",
                      rsp_filtered_value, rsp_frame_last);
               new_errors++;
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_filtered_value !== oldest.value) begin
                  $error("filtered_value: expected %0d, actual %0d",
                         oldest.value, rsp_filtered_value);
                  new_errors++;
               end
               if (rsp_frame_last !== oldest.last) begin
                  $error("frame_last: expected %0b, actual %0b",
                         oldest.last, rsp_frame_last);
                  new_errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            filter_pixel(req_pixel, req_frame_start);
         end
      end
      failures <= reset ? 0 : failures + new_errors;
      pending <= expected_results.size();
   end

endmodule

### test/testbench.sv
// Top of the gated 3x3 box filter testbench: clock, reset, pixel stream and verdict
`timescale 1ns / 1ps

module testbench;
   import gbf_pkg::*;

   localparam int unsigned DRAIN_CYCLES  = 12;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned PHASE_PIXELS  = 110;
   localparam int unsigned TALL_PIXELS   = 100;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [PIX_W-1:0]    req_pixel = '0;
   logic                req_frame_start = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [PIX_W-1:0]    rsp_filtered_value;
   logic                rsp_frame_last;
   logic                csr_wr_en = 1'b0;
   csr_index_type       csr_index = CSR_LINE_WIDTH;
   logic [SIZE_W-1:0]   csr_wr_data = '0;

   int                  failures;
   int                  pending;
   int unsigned         idle_pct = 0;
   int unsigned         stall_pct = 0;
   int unsigned         hold_requests = 0;
   int unsigned         holds_served = 0;
   int unsigned         hold_left = 0;
   int unsigned         active_width = LINE_WIDTH_RESET;
   int unsigned         frame_len = LINE_WIDTH_RESET * FRAME_HEIGHT_RESET;
   int unsigned         frame_pos = 0;
   logic                start_due = 1'b0;

   always #2 clock = ~clock;

   gated_box_filter_3x3_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel          (req_pixel),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_frame_last     (rsp_frame_last),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   box_filter_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel          (req_pixel),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_frame_last     (rsp_frame_last),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .failures           (failures),
      .pending            (pending)
   );

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic put_pixel(input logic [PIX_W-1:0] pix, input logic fs);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      req_frame_start <= fs;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      frame_pos = fs ? 1 : frame_pos + 1;
      if (frame_pos >= frame_len) begin
         frame_pos = 0;
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [SIZE_W-1:0] w_raw, input logic [SIZE_W-1:0] h_raw);
      int unsigned w_eff;
      int unsigned h_eff;
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_LINE_WIDTH;
      csr_wr_data <= w_raw;
      @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wr_data <= h_raw;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      w_eff = (w_raw < MIN_SIZE) ? MIN_SIZE : (w_raw > MAX_LINE) ? MAX_LINE : w_raw;
      h_eff = (h_raw < MIN_SIZE) ? MIN_SIZE : (h_raw > MAX_ROWS) ? MAX_ROWS : h_raw;
      // a wider row mid-frame would read line-store entries never written
      start_due = w_eff > active_width;
      active_width = w_eff;
      frame_len = w_eff * h_eff;
      if (start_due || frame_pos >= frame_len) begin
         frame_pos = 0;
      end
   endtask

   task automatic random_pixels(input int unsigned count);
      logic [PIX_W-1:0] pix;
      logic             fs;
      repeat (count) begin
         case ($urandom_range(9))
            0: pix = '0;
            1: pix = '1;
            2, 3: pix = PIX_W'($urandom_range(135, 120));
            default: pix = PIX_W'($urandom_range(255));
         endcase
         fs = start_due || (frame_pos == 0 && $urandom_range(1) == 1) ||
              $urandom_range(63) == 0;
         start_due = 1'b0;
         put_pixel(pix, fs);
      end
   endtask

   initial begin
      logic [PIX_W-1:0]  centre_vals [3];
      logic [PIX_W-1:0]  around_vals [3];
      logic [SIZE_W-1:0] w_raw;
      logic [SIZE_W-1:0] h_raw;
      centre_vals = '{8'd255, 8'd128, 8'd127};
      around_vals = '{8'd255, 8'd0, 8'd255};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // smallest frame, reached by saturating both registers from below
      configure(11'd0, 11'd2);
      // full-scale mean, gate just met, gate just missed; second frame wraps without a start
      for (int f = 0; f < 3; f++) begin
         for (int k = 0; k < 9; k++) begin
            put_pixel(k == 4 ? centre_vals[f] : around_vals[f], k == 0 && f != 1);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(9))
            0: w_raw = SIZE_W'($urandom_range(2));
            1: w_raw = SIZE_W'($urandom_range(40, 13));
            default: w_raw = SIZE_W'($urandom_range(12, 3));
         endcase
         case ($urandom_range(9))
            0: h_raw = SIZE_W'($urandom_range(2));
            1: h_raw = SIZE_W'($urandom_range(20, 9));
            default: h_raw = SIZE_W'($urandom_range(8, 3));
         endcase
         configure(w_raw, h_raw);
         case (p % 4)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 57;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 57;
            end
            default: begin
               idle_pct = 10;
               stall_pct = 10;
            end
         endcase
         if (p == 4) begin
            hold_requests++;
         end
         random_pixels(PHASE_PIXELS);
      end

      // tallest frame, reached by saturating the height register from above
      idle_pct = 0;
      stall_pct = 10;
      configure(11'd3, 11'h7FF);
      random_pixels(TALL_PIXELS);

      wait_idle();
      if (failures == 0) begin
         $display("** gated_box_filter_3x3_top: PASSED **");
      end else begin
         $display("** gated_box_filter_3x3_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #(4_000_000);
      $display("** gated_box_filter_3x3_top: FAILED **");
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/gbf_pkg.sv
hw/rtl/gbf_ram.sv
hw/rtl/gbf_window.sv
hw/rtl/gbf_fifo.sv
hw/rtl/gated_box_filter_3x3_top.sv
test/box_filter_checker.sv
test/testbench.sv
